### sv/sh24_pkg.sv
// SipHash-2-4 package: lane types, key type, initialization constants and
// the rotate helper used by the round unit.
// No dependencies.
package sh24_pkg;

   localparam int unsigned LANE_W  = 64;
   localparam int unsigned LEN_W   = 8;
   localparam int unsigned COUNT_W = 4;

   localparam logic [LANE_W-1:0] SIP_C0 = 64'h736f6d6570736575;
   localparam logic [LANE_W-1:0] SIP_C1 = 64'h646f72616e646f6d;
   localparam logic [LANE_W-1:0] SIP_C2 = 64'h6c7967656e657261;
   localparam logic [LANE_W-1:0] SIP_C3 = 64'h7465646279746573;

   localparam logic [LANE_W-1:0] FINAL_XOR = 64'h0000_0000_0000_00ff;
   localparam int unsigned       LEN_SHIFT = 56;

   localparam int unsigned ROT_A = 13;
   localparam int unsigned ROT_B = 16;
   localparam int unsigned ROT_C = 21;
   localparam int unsigned ROT_D = 17;
   localparam int unsigned ROT_H = 32;

   localparam logic CSR_KEY_LOW  = 1'b0;
   localparam logic CSR_KEY_HIGH = 1'b1;

   typedef logic [3:0][LANE_W-1:0] lanes_type;

   typedef struct packed {
      logic [LANE_W-1:0] low;
      logic [LANE_W-1:0] high;
   } key_type;

   function automatic logic [LANE_W-1:0] rotl64(input logic [LANE_W-1:0] x,
                                                input int unsigned r);
      return (x << r) | (x >> (LANE_W - r));
   endfunction

endpackage

### sv/sh24_round.sv
// One SipRound over the four lanes, purely combinational.
// Depends on sh24_pkg.
module sh24_round (
   input  sh24_pkg::lanes_type lanes_i,
   output sh24_pkg::lanes_type lanes_o
);
   import sh24_pkg::*;

   logic [LANE_W-1:0] v0a, v1a, v2a, v3a;
   logic [LANE_W-1:0] v0b, v1b, v2b, v3b;

   always_comb begin
      // first half
      v0a = lanes_i[0] + lanes_i[1];
      v1a = rotl64(lanes_i[1], ROT_A) ^ v0a;
      v0a = rotl64(v0a, ROT_H);
      v2a = lanes_i[2] + lanes_i[3];
      v3a = rotl64(lanes_i[3], ROT_B) ^ v2a;
      // second half
      v0b = v0a + v3a;
      v3b = rotl64(v3a, ROT_C) ^ v0b;
      v2b = v2a + v1a;
      v1b = rotl64(v1a, ROT_D) ^ v2b;
      v2b = rotl64(v2b, ROT_H);
      lanes_o[0] = v0b;
      lanes_o[1] = v1b;
      lanes_o[2] = v2b;
      lanes_o[3] = v3b;
   end

endmodule

### sv/sh24_core.sv
// SipHash-2-4 sequencer: lane registers, block packing and the result
// register, driving one shared SipRound unit. Depends on sh24_pkg, sh24_round.
module sh24_core (
   input  logic                             clock,
   input  logic                             reset,
   input  sh24_pkg::key_type                key_i,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [sh24_pkg::LANE_W-1:0]      req_message_word,
   input  logic [sh24_pkg::COUNT_W-1:0]     req_byte_count,
   input  logic                             req_end_of_message,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [sh24_pkg::LANE_W-1:0]      rsp_hash_value
);
   import sh24_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_ABSORB, S_FINAL} state_type;

   state_type         state_ff, state_in;
   lanes_type         lanes_ff, lanes_in;
   logic [LANE_W-1:0] msg_ff, msg_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              in_msg_ff, in_msg_in;
   logic              pending_ff, pending_in;
   logic              final_ff, final_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [LANE_W-1:0] hash_ff, hash_in;

   lanes_type         rnd_out;
   lanes_type         after_abs;
   lanes_type         base;
   logic              can_take;
   logic              accept;
   logic [COUNT_W-1:0] count_c;
   logic              full_w;
   logic [LEN_W-1:0]  len_base;
   logic [LEN_W-1:0]  len_new;
   logic [LANE_W-1:0] mask;
   logic [LANE_W-1:0] block;

   sh24_round u_round (
      .lanes_i (lanes_ff),
      .lanes_o (rnd_out)
   );

   always_comb begin
      after_abs    = rnd_out;
      after_abs[0] = rnd_out[0] ^ msg_ff;

      can_take  = (state_ff == S_IDLE) ||
                  (state_ff == S_ABSORB && cnt_ff == 2'd1 && !pending_ff && !final_ff);
      req_stall = !can_take;
      accept    = req_valid && can_take;

      count_c = (req_byte_count > COUNT_W'(8)) ? COUNT_W'(8) : req_byte_count;
      full_w  = !req_end_of_message || count_c[3];
      // restart the length count on the first request of a message
      len_base = in_msg_ff ? len_ff : '0;
      len_new  = full_w ? len_base + LEN_W'(8) : len_base + LEN_W'(count_c);
      mask    = (LANE_W'(1) << {count_c[2:0], 3'b000}) - LANE_W'(1);
      block   = full_w ? req_message_word
                       : ((req_message_word & mask) | ({56'd0, len_new} << LEN_SHIFT));

      // new message: key init lanes; idle: current lanes; else finished word
      base = (state_ff == S_IDLE) ? lanes_ff : after_abs;
      if (!in_msg_ff) begin
         base[0] = SIP_C0 ^ key_i.low;
         base[1] = SIP_C1 ^ key_i.high;
         base[2] = SIP_C2 ^ key_i.low;
         base[3] = SIP_C3 ^ key_i.high;
      end

      state_in     = state_ff;
      lanes_in     = lanes_ff;
      msg_in       = msg_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      in_msg_in    = in_msg_ff;
      pending_in   = pending_ff;
      final_in     = final_ff;
      hash_in      = hash_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               lanes_in    = base;
               lanes_in[3] = base[3] ^ block;
               msg_in      = block;
               len_in      = len_new;
               in_msg_in   = 1'b1;
               pending_in  = req_end_of_message && count_c[3];
               final_in    = req_end_of_message;
               cnt_in      = 2'd0;
               state_in    = S_ABSORB;
            end
         end
         S_ABSORB: begin
            lanes_in = rnd_out;
            cnt_in   = cnt_ff + 2'd1;
            if (cnt_ff == 2'd1) begin
               lanes_in = after_abs;
               cnt_in   = 2'd0;
               if (pending_ff) begin
                  // length-only block after a full end word
                  msg_in      = {len_ff, 56'd0};
                  lanes_in[3] = after_abs[3] ^ {len_ff, 56'd0};
                  pending_in  = 1'b0;
               end else if (final_ff) begin
                  lanes_in[2] = after_abs[2] ^ FINAL_XOR;
                  state_in    = S_FINAL;
               end else if (accept) begin
                  lanes_in    = base;
                  lanes_in[3] = base[3] ^ block;
                  msg_in      = block;
                  len_in      = len_new;
                  pending_in  = req_end_of_message && count_c[3];
                  final_in    = req_end_of_message;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_FINAL: begin
            if (cnt_ff != 2'd3) begin
               lanes_in = rnd_out;
               cnt_in   = cnt_ff + 2'd1;
            end else if (!(rsp_valid_ff && rsp_stall)) begin
               // hold the last round until the result register frees up
               lanes_in     = rnd_out;
               hash_in      = rnd_out[0] ^ rnd_out[1] ^ rnd_out[2] ^ rnd_out[3];
               rsp_valid_in = 1'b1;
               in_msg_in    = 1'b0;
               final_in     = 1'b0;
               cnt_in       = 2'd0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lanes_ff     <= '0;
         len_ff       <= '0;
         cnt_ff       <= '0;
         in_msg_ff    <= 1'b0;
         pending_ff   <= 1'b0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lanes_ff     <= lanes_in;
         len_ff       <= len_in;
         cnt_ff       <= cnt_in;
         in_msg_ff    <= in_msg_in;
         pending_ff   <= pending_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      msg_ff  <= msg_in;
      hash_ff <= hash_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = hash_ff;

   a_final_flag: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FINAL |-> final_ff && !pending_ff)
      else $error("final state without end request");

   a_pending_final: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> final_ff)
      else $error("length block pending outside an end request");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINAL && cnt_ff == 2'd3))
      else $error("result raised outside finalization");

   a_absorb_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ABSORB |-> cnt_ff == 2'd0 || cnt_ff == 2'd1)
      else $error("absorb round count out of range");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FINAL |-> req_stall)
      else $error("request taken during finalization");

endmodule

### sv/siphash_2_4_keyed_hash_top.sv
// Top level of the keyed SipHash-2-4 block: key registers on the CSR port
// and the hashing core. Depends on sh24_pkg, sh24_core.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  req     | req_valid/stall    | message_word[63:0] byte_count[3:0] eom
//  rsp     | rsp_valid/stall    | hash_value[63:0]
//  csr     | csr_valid/ready    | csr_index (0 key_low, 1 key_high), wdata
//
// A word request gets its compression rounds, one SipRound per cycle on the single round
// unit; the next word may be taken in the second round cycle.
// An end request with 8 bytes adds an extra length block before finalization;
// one with fewer than 8 bytes carries its length in its last word.
// Synchronous reset clears lanes, length, keys and the result valid flag.
// A stalled result holds finalization in its last round until it drains.
module siphash_2_4_keyed_hash_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sh24_pkg::LANE_W-1:0]   req_message_word,
   input  logic [sh24_pkg::COUNT_W-1:0]  req_byte_count,
   input  logic                          req_end_of_message,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sh24_pkg::LANE_W-1:0]   rsp_hash_value,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [sh24_pkg::LANE_W-1:0]   csr_wdata
);
   import sh24_pkg::*;

   key_type key_ff, key_in;

   assign csr_ready = 1'b1;

   always_comb begin
      key_in = key_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_KEY_LOW:  key_in.low  = csr_wdata;
            CSR_KEY_HIGH: key_in.high = csr_wdata;
            default:      key_in      = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   sh24_core u_core (
      .clock              (clock),
      .reset              (reset),
      .key_i              (key_ff),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_message_word   (req_message_word),
      .req_byte_count     (req_byte_count),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hash_value     (rsp_hash_value)
   );

endmodule
